// ===== rtl/core/lpc_pkg.sv =====
// Shared types and constants of the page cache with readahead.
`timescale 1ns / 1ps

package lpc_pkg;

	localparam int ENTRIES   = 5;
	localparam int PAGE_BITS = 16;
	localparam int DOC_BITS  = 8;
	localparam int ANGLE_W   = 2;
	localparam int RES_W     = 12;
	localparam int COUNT_W   = PAGE_BITS;
	localparam int PREV_W    = PAGE_BITS + 1;
	localparam int POS_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W    = 3;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_DEMAND    = 2'd0,
		REQ_READAHEAD = 2'd1,
		REQ_FLUSH     = 2'd2,
		REQ_FLUSH_ALT = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT     = 3'd0,
		ST_MISS    = 3'd1,
		ST_RANGE   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_FLUSHED = 3'd4,
		ST_SKIPPED = 3'd5
	} status_t;

	typedef struct packed {
		logic [DOC_BITS-1:0]  doc;
		logic [PAGE_BITS-1:0] page;
		logic [ANGLE_W-1:0]   angle;
		logic [RES_W-1:0]     res;
	} key_t;

	typedef struct packed {
		logic fire;
		logic flush;
		logic lookup;
		key_t key;
	} tag_req_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] buf_slot;
	} tag_resp_t;

	typedef struct packed {
		logic                 fire;
		logic                 clear;
		logic                 demand_ok;
		logic [PAGE_BITS-1:0] page;
	} ra_req_t;

	typedef struct packed {
		logic                 offer;
		logic [PAGE_BITS-1:0] page;
		logic                 busy;
	} ra_resp_t;

endpackage

// ===== rtl/core/lru_page_cache_with_readahead_unit.sv =====
// Top level of the move-to-front page cache with one-page readahead.
`timescale 1ns / 1ps

// A request transaction is captured in an input register and resolved from
// there against the five-entry tag store: all entries are compared
// in parallel, and the hit or replaced entry moves to the front as the
// result is written to the output register. One request is taken every cycle
// while the output register is empty or being read; the tag store compares
// and shifts between the two registers. A result waiting in the
// output register stalls the input only when the input register is also full.

module lru_page_cache_with_readahead_unit import lpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [DOC_BITS-1:0]  doc_id,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic [ANGLE_W-1:0]   angle_code,
	input  logic [RES_W-1:0]     resolution,
	input  logic [COUNT_W-1:0]   page_count,
	input  logic                 forward_only,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic                 hit,
	output logic [SLOT_W-1:0]    buffer_slot,
	output logic [SLOT_W-1:0]    found_position,
	output logic                 prefetch_valid,
	output logic [PAGE_BITS-1:0] prefetch_page,
	output logic                 prefetch_busy
);

	logic                 v_s1;
	req_type_t            req_s1;
	key_t                 key_s1;
	logic [COUNT_W-1:0]   count_s1;
	logic                 fwd_s1;

	logic                 v_s2;
	status_t              status_s2;
	logic                 hit_s2;
	logic [SLOT_W-1:0]    slot_s2;
	logic [SLOT_W-1:0]    pos_s2;
	logic                 pf_valid_s2;
	logic [PAGE_BITS-1:0] pf_page_s2;
	logic                 busy_s2;

	logic      advance;
	logic      fire;
	logic      is_flush;
	logic      is_ra;
	logic      is_demand;
	logic      out_of_range;
	logic      demand_ok;
	logic      do_lookup;
	status_t   status_c;
	tag_req_t  tag_req;
	tag_resp_t tag_resp;
	ra_req_t   ra_req;
	ra_resp_t  ra_resp;

	assign advance  = !v_s2 || out_ready;
	assign fire     = v_s1 && advance;
	assign in_ready = !v_s1 || advance;

	always_comb begin
		is_flush     = req_s1 == REQ_FLUSH || req_s1 == REQ_FLUSH_ALT;
		is_ra        = req_s1 == REQ_READAHEAD;
		is_demand    = req_s1 == REQ_DEMAND;
		out_of_range = (key_s1.page >= count_s1) && !fwd_s1;
		demand_ok    = is_demand && (count_s1 != '0) && !out_of_range;
		do_lookup    = demand_ok || (is_ra && !fwd_s1 && !out_of_range);
		priority if (is_flush) begin
			status_c = ST_FLUSHED;
		end else if (is_ra && fwd_s1) begin
			status_c = ST_SKIPPED;
		end else if (is_demand && count_s1 == '0) begin
			status_c = ST_EMPTY;
		end else if (out_of_range) begin
			status_c = ST_RANGE;
		end else if (tag_resp.hit) begin
			status_c = ST_HIT;
		end else begin
			status_c = ST_MISS;
		end
	end

	assign tag_req.fire   = fire;
	assign tag_req.flush  = is_flush;
	assign tag_req.lookup = do_lookup;
	assign tag_req.key    = key_s1;

	lpc_tag_store u_tags (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tag_req),
		.resp   (tag_resp)
	);

	assign ra_req.fire      = fire;
	assign ra_req.clear     = is_ra;
	assign ra_req.demand_ok = demand_ok;
	assign ra_req.page      = key_s1.page;

	lpc_readahead u_ra (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ra_req),
		.resp   (ra_resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (advance) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1       <= req_type_t'(req_type);
			key_s1.doc   <= doc_id;
			key_s1.page  <= page_number;
			key_s1.angle <= angle_code;
			key_s1.res   <= resolution;
			count_s1     <= page_count;
			fwd_s1       <= forward_only;
		end
		if (fire) begin
			status_s2   <= status_c;
			hit_s2      <= do_lookup && tag_resp.hit;
			slot_s2     <= do_lookup ? SLOT_W'(tag_resp.buf_slot) : '0;
			pos_s2      <= do_lookup ? SLOT_W'(tag_resp.pos) : '0;
			pf_valid_s2 <= ra_resp.offer;
			pf_page_s2  <= ra_resp.offer ? ra_resp.page : '0;
			busy_s2     <= ra_resp.busy;
		end
	end

	assign out_valid      = v_s2;
	assign status         = status_s2;
	assign hit            = hit_s2;
	assign buffer_slot    = slot_s2;
	assign found_position = pos_s2;
	assign prefetch_valid = pf_valid_s2;
	assign prefetch_page  = pf_page_s2;
	assign prefetch_busy  = busy_s2;

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (status == ST_HIT)))
		else $error("hit flag disagrees with status");

	a_prefetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prefetch_valid |-> prefetch_busy)
		else $error("prefetch offered without busy flag");

endmodule

// ===== rtl/core/lpc_tag_store.sv =====
// Fully associative tag store kept in move-to-front order.
`timescale 1ns / 1ps

module lpc_tag_store import lpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tag_req_t  req,
	output tag_resp_t resp
);

	logic [ENTRIES-1:0] valid_q;
	key_t               key_q [ENTRIES];
	logic [POS_W-1:0]   buf_q [ENTRIES];

	logic [ENTRIES-1:0] match;
	logic               hit;
	logic [POS_W-1:0]   hit_pos;
	logic [POS_W-1:0]   free_pos;
	logic [POS_W-1:0]   pos;
	logic [POS_W-1:0]   buf_sel;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req.key);
		end
		// Scan from the back so the lowest position wins.
		hit      = 1'b0;
		hit_pos  = '0;
		free_pos = POS_W'(ENTRIES - 1);
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_pos = POS_W'(i);
			end
			if (!valid_q[i]) begin
				free_pos = POS_W'(i);
			end
		end
		pos     = hit ? hit_pos : free_pos;
		buf_sel = buf_q[pos];
	end

	assign resp.hit      = hit;
	assign resp.pos      = pos;
	assign resp.buf_slot = buf_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				buf_q[i] <= POS_W'(i);
			end
		end else if (req.fire) begin
			if (req.flush) begin
				valid_q <= '0;
			end else if (req.lookup) begin
				valid_q[0] <= 1'b1;
				buf_q[0]   <= buf_sel;
				for (int i = 1; i < ENTRIES; i++) begin
					if (i <= int'(pos)) begin
						valid_q[i] <= valid_q[i-1];
						buf_q[i]   <= buf_q[i-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.fire && !req.flush && req.lookup) begin
			key_q[0] <= req.key;
			for (int i = 1; i < ENTRIES; i++) begin
				if (i <= int'(pos)) begin
					key_q[i] <= key_q[i-1];
				end
			end
		end
	end

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req.fire && req.flush |=> valid_q == '0)
		else $error("flush left a valid entry");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key present in more than one entry");

endmodule

// ===== rtl/core/lpc_readahead.sv =====
// Sequential step detector and readahead bookkeeping.
`timescale 1ns / 1ps

module lpc_readahead import lpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ra_req_t  req,
	output ra_resp_t resp
);

	logic [PREV_W-1:0] prev_q;
	logic              pend_q;

	logic [PREV_W-1:0] page_ext;
	logic [PREV_W-1:0] prev_inc;
	logic [PREV_W-1:0] prev_dec;
	logic              step_up;
	logic              step_down;
	logic              offer;

	always_comb begin
		page_ext  = {1'b0, req.page};
		prev_inc  = prev_q + PREV_W'(1);
		prev_dec  = prev_q - PREV_W'(1);
		step_up   = page_ext == prev_inc;
		step_down = page_ext == prev_dec;
		offer     = 1'b0;
		if (req.demand_ok && !pend_q) begin
			priority if (step_up) begin
				offer = req.page != '1;
			end else if (step_down) begin
				offer = req.page != '0;
			end else begin
				offer = 1'b0;
			end
		end
	end

	assign resp.offer = offer;
	assign resp.page  = step_up ? req.page + PAGE_BITS'(1) : req.page - PAGE_BITS'(1);
	assign resp.busy  = req.clear ? 1'b0 : (offer ? 1'b1 : pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '1;
			pend_q <= 1'b0;
		end else if (req.fire) begin
			pend_q <= resp.busy;
			if (req.demand_ok) begin
				prev_q <= page_ext;
			end
		end
	end

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req.fire && req.clear |=> !pend_q)
		else $error("readahead lookup did not clear pending flag");

	a_offer_sets: assert property (@(posedge clk) disable iff (!arst_n)
		req.fire && offer |=> pend_q)
		else $error("offered readahead not marked pending");

endmodule

// ===== tb/lru_page_cache_with_readahead_unit_tb.sv =====
// Self-checking testbench of the page cache with one-page readahead.
`timescale 1ns / 1ps

module lru_page_cache_with_readahead_unit_tb;
	import lpc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_CAP  = 200;

	typedef struct {
		req_type_t            req;
		logic [DOC_BITS-1:0]  doc;
		logic [PAGE_BITS-1:0] page;
		logic [ANGLE_W-1:0]   angle;
		logic [RES_W-1:0]     res;
		logic [COUNT_W-1:0]   count;
		logic                 fwd;
	} page_request_t;

	typedef struct {
		status_t              status;
		logic                 hit;
		logic [SLOT_W-1:0]    slot;
		logic [SLOT_W-1:0]    pos;
		logic                 pf_valid;
		logic [PAGE_BITS-1:0] pf_page;
		logic                 pf_busy;
	} cache_answer_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [REQ_W-1:0]     req_type;
	logic [DOC_BITS-1:0]  doc_id;
	logic [PAGE_BITS-1:0] page_number;
	logic [ANGLE_W-1:0]   angle_code;
	logic [RES_W-1:0]     resolution;
	logic [COUNT_W-1:0]   page_count;
	logic                 forward_only;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic                 hit;
	logic [SLOT_W-1:0]    buffer_slot;
	logic [SLOT_W-1:0]    found_position;
	logic                 prefetch_valid;
	logic [PAGE_BITS-1:0] prefetch_page;
	logic                 prefetch_busy;

	// Predicted contents of the tag store, kept in recency order.
	logic                 tag_valid [ENTRIES];
	key_t                 tag_key [ENTRIES];
	logic [SLOT_W-1:0]    tag_buf [ENTRIES];
	logic [PREV_W-1:0]    last_demand_page;
	logic                 readahead_busy;

	cache_answer_t        expected_results [$];
	cache_answer_t        oldest_expected;
	int                   mismatches = 0;
	int                   burst_left = 0;
	int                   quiet_cycles = 0;
	logic [15:0]          rx_tick = '0;

	lru_page_cache_with_readahead_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.doc_id         (doc_id),
		.page_number    (page_number),
		.angle_code     (angle_code),
		.resolution     (resolution),
		.page_count     (page_count),
		.forward_only   (forward_only),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.hit            (hit),
		.buffer_slot    (buffer_slot),
		.found_position (found_position),
		.prefetch_valid (prefetch_valid),
		.prefetch_page  (prefetch_page),
		.prefetch_busy  (prefetch_busy)
	);

	always #10 clk = ~clk;

	task automatic cache_model_reset();
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			tag_valid[i] = 1'b0;
			tag_key[i]   = '0;
			tag_buf[i]   = SLOT_W'(i);
		end
		last_demand_page = '1;
		readahead_busy   = 1'b0;
	endtask

	// Hit or replacement, then move the chosen entry to the front.
	task automatic cache_lookup(input key_t k, inout cache_answer_t a);
		int                pos;
		int                i;
		logic [SLOT_W-1:0] slot;
		pos = -1;
		for (i = 0; i < ENTRIES; i++)
			if (pos < 0 && tag_valid[i] && tag_key[i] == k) pos = i;
		if (pos >= 0) begin
			a.hit    = 1'b1;
			a.status = ST_HIT;
		end else begin
			a.hit    = 1'b0;
			a.status = ST_MISS;
			// The first empty entry wins; with none empty the oldest one is reused.
			pos = ENTRIES - 1;
			for (i = ENTRIES - 1; i >= 0; i--)
				if (!tag_valid[i]) pos = i;
		end
		slot = tag_buf[pos];
		for (i = pos; i > 0; i--) begin
			tag_valid[i] = tag_valid[i-1];
			tag_key[i]   = tag_key[i-1];
			tag_buf[i]   = tag_buf[i-1];
		end
		tag_valid[0] = 1'b1;
		tag_key[0]   = k;
		tag_buf[0]   = slot;
		a.slot = slot;
		a.pos  = SLOT_W'(pos);
	endtask

	task automatic cache_predict(input page_request_t r, output cache_answer_t a);
		key_t              k;
		logic              out_of_range;
		logic [PREV_W-1:0] page_ext;
		logic [PREV_W-1:0] step_up;
		logic [PREV_W-1:0] step_down;
		int                i;
		k.doc   = r.doc;
		k.page  = r.page;
		k.angle = r.angle;
		k.res   = r.res;
		out_of_range = (r.page >= r.count) && !r.fwd;
		page_ext  = {1'b0, r.page};
		step_up   = last_demand_page + 1'b1;
		step_down = last_demand_page - 1'b1;
		a.status   = ST_FLUSHED;
		a.hit      = 1'b0;
		a.slot     = '0;
		a.pos      = '0;
		a.pf_valid = 1'b0;
		a.pf_page  = '0;
		if (r.req == REQ_FLUSH || r.req == REQ_FLUSH_ALT) begin
			for (i = 0; i < ENTRIES; i++)
				tag_valid[i] = 1'b0;
		end else if (r.req == REQ_READAHEAD) begin
			readahead_busy = 1'b0;
			if (r.fwd)
				a.status = ST_SKIPPED;
			else if (out_of_range)
				a.status = ST_RANGE;
			else
				cache_lookup(k, a);
		end else if (r.count == '0) begin
			a.status = ST_EMPTY;
		end else if (out_of_range) begin
			a.status = ST_RANGE;
		end else begin
			cache_lookup(k, a);
			if (!readahead_busy) begin
				if (page_ext == step_up) begin
					if (r.page != '1) begin
						a.pf_valid = 1'b1;
						a.pf_page  = r.page + 1'b1;
					end
				end else if (page_ext == step_down) begin
					if (r.page != '0) begin
						a.pf_valid = 1'b1;
						a.pf_page  = r.page - 1'b1;
					end
				end
				if (a.pf_valid) readahead_busy = 1'b1;
			end
			last_demand_page = page_ext;
		end
		a.pf_busy = readahead_busy;
	endtask

	function automatic page_request_t make_request(input req_type_t req,
			input logic [DOC_BITS-1:0] doc, input logic [PAGE_BITS-1:0] page,
			input logic [ANGLE_W-1:0] angle, input logic [RES_W-1:0] res,
			input logic [COUNT_W-1:0] count, input logic fwd);
		page_request_t r;
		r.req   = req;
		r.doc   = doc;
		r.page  = page;
		r.angle = angle;
		r.res   = res;
		r.count = count;
		r.fwd   = fwd;
		return r;
	endfunction

	// Drives one request transaction; bursts of random length with random gaps.
	task automatic send_request(input page_request_t r, output cache_answer_t a);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid     <= 1'b1;
		req_type     <= r.req;
		doc_id       <= r.doc;
		page_number  <= r.page;
		angle_code   <= r.angle;
		resolution   <= r.res;
		page_count   <= r.count;
		forward_only <= r.fwd;
		do @(posedge clk); while (!in_ready);
		cache_predict(r, a);
		expected_results.push_back(a);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < REPORT_CAP)
			$display("%0t: %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	task automatic test_directed_cases();
		cache_answer_t a;
		int            p;
		// First demand steps up from the reset value of minus one.
		send_request(make_request(REQ_DEMAND, 8'd0, 16'd0, 2'd0, 12'd1, 16'd1, 1'b0), a);
		send_request(make_request(REQ_DEMAND, 8'd0, 16'd0, 2'd0, 12'd1, 16'd1, 1'b0), a);
		send_request(make_request(REQ_READAHEAD, 8'd0, 16'd1, 2'd0, 12'd1, 16'd1, 1'b0), a);
		send_request(make_request(REQ_DEMAND, 8'd9, 16'd3, 2'd0, 12'd1, 16'd0, 1'b0), a);
		send_request(make_request(REQ_DEMAND, 8'd9, 16'd3, 2'd0, 12'd1, 16'd0, 1'b1), a);
		// A readahead skips the empty document check.
		send_request(make_request(REQ_READAHEAD, 8'd0, 16'd0, 2'd0, 12'd1, 16'd0, 1'b0), a);
		send_request(make_request(REQ_DEMAND, 8'hFF, 16'hFFFF, 2'd3, 12'hFFF, 16'hFFFF, 1'b0), a);
		send_request(make_request(REQ_DEMAND, 8'hFF, 16'hFFFF, 2'd3, 12'hFFF, 16'hFFFF, 1'b1), a);
		send_request(make_request(REQ_DEMAND, 8'hFF, 16'hFFFE, 2'd3, 12'hFFF, 16'hFFFF, 1'b0), a);
		send_request(make_request(REQ_READAHEAD, 8'hFF, 16'hFFFD, 2'd3, 12'hFFF, 16'hFFFF, 1'b1),
			a);
		// Step up onto the largest page has nowhere to prefetch.
		send_request(make_request(REQ_DEMAND, 8'hFF, 16'hFFFF, 2'd3, 12'hFFF, 16'hFFFF, 1'b1), a);
		send_request(make_request(REQ_DEMAND, 8'd0, 16'd1, 2'd1, 12'd2, 16'd100, 1'b0), a);
		// Step down onto page zero has nowhere to prefetch either.
		send_request(make_request(REQ_DEMAND, 8'd0, 16'd0, 2'd1, 12'd2, 16'd100, 1'b0), a);
		send_request(make_request(REQ_DEMAND, 8'd0, 16'd1, 2'd1, 12'd2, 16'd100, 1'b0), a);
		send_request(make_request(REQ_READAHEAD, 8'd0, 16'd2, 2'd1, 12'd2, 16'd100, 1'b0), a);
		for (p = 20; p < 25; p++)
			send_request(make_request(REQ_DEMAND, 8'd7, 16'(p), 2'd2, 12'hFFF, 16'd100, 1'b0),
				a);
		send_request(make_request(REQ_DEMAND, 8'd0, 16'd1, 2'd1, 12'd2, 16'd100, 1'b0), a);
		send_request(make_request(REQ_FLUSH, 8'd0, 16'd0, 2'd0, 12'd0, 16'd0, 1'b0), a);
		send_request(make_request(REQ_DEMAND, 8'd0, 16'd1, 2'd1, 12'd2, 16'd100, 1'b0), a);
		send_request(make_request(REQ_FLUSH_ALT, 8'hFF, 16'hFFFF, 2'd3, 12'hFFF, 16'hFFFF, 1'b1),
			a);
		send_request(make_request(REQ_READAHEAD, 8'd0, 16'd1, 2'd1, 12'd2, 16'd100, 1'b0), a);
	endtask

	// Short runs of consecutive pages, each followed by a full drain.
	task automatic test_pause_until_drained();
		cache_answer_t a;
		int            base;
		int            j;
		repeat (8) begin
			base = $urandom_range(0, 50);
			for (j = 0; j < 5; j++)
				send_request(make_request(REQ_DEMAND, 8'd5, 16'(base + j), 2'd0, 12'd96,
					16'd64, 1'b0), a);
			wait_for_results();
		end
	endtask

	// Page-by-page reading of documents, mostly small, following most of the offered readaheads.
	task automatic test_sequential_reading(input int n_items);
		page_request_t r;
		cache_answer_t a;
		int            sent;
		int            page;
		int            count;
		int            pick;
		sent = 0;
		while (sent < n_items) begin
			r.doc   = DOC_BITS'($urandom_range(0, 3));
			count   = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(6, 40);
			r.count = COUNT_W'(count);
			case ($urandom_range(0, 2))
				0: r.res = 12'd72;
				1: r.res = 12'd150;
				default: r.res = 12'd300;
			endcase
			r.angle = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom) : 2'd0;
			if (count == 65535 && $urandom_range(0, 1) == 1)
				page = 65535 - $urandom_range(0, 3);
			else
				page = $urandom_range(0, count - 1);
			repeat ($urandom_range(4, 30)) begin
				r.req  = REQ_DEMAND;
				r.fwd  = ($urandom_range(0, 7) == 0);
				r.page = ($urandom_range(0, 15) == 0) ? PAGE_BITS'(count + $urandom_range(0, 2))
					: PAGE_BITS'(page);
				send_request(r, a);
				sent++;
				if (a.pf_valid && $urandom_range(0, 3) != 0) begin
					r.req  = REQ_READAHEAD;
					r.page = a.pf_page;
					r.fwd  = ($urandom_range(0, 7) == 0);
					send_request(r, a);
					sent++;
				end
				pick = $urandom_range(0, 11);
				if (pick < 6)
					page = (page + 1 < count) ? page + 1 : page - 1;
				else if (pick < 9)
					page = (page > 0) ? page - 1 : page + 1;
				else if (pick == 10)
					page = $urandom_range(0, count - 1);
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				r.req = REQ_FLUSH;
				send_request(r, a);
				sent++;
			end else if (pick == 1) begin
				r.req = REQ_FLUSH_ALT;
				send_request(r, a);
				sent++;
			end else if (pick == 2) begin
				wait_for_results();
			end
		end
	endtask

	task automatic test_random_noise(input int n_items);
		page_request_t r;
		cache_answer_t a;
		repeat (n_items) begin
			r.req   = req_type_t'($urandom_range(0, 3));
			r.doc   = ($urandom_range(0, 1) == 1) ? DOC_BITS'($urandom)
				: DOC_BITS'($urandom_range(0, 3));
			r.page  = ($urandom_range(0, 1) == 1) ? PAGE_BITS'($urandom)
				: PAGE_BITS'($urandom_range(0, 8));
			case ($urandom_range(0, 3))
				0: r.count = '0;
				1: r.count = COUNT_W'($urandom);
				default: r.count = COUNT_W'($urandom_range(0, 10));
			endcase
			r.angle = ANGLE_W'($urandom);
			r.res   = RES_W'($urandom);
			r.fwd   = 1'($urandom_range(0, 1));
			send_request(r, a);
		end
	endtask

	// The receiver cycles through always ready, random, one in three, and long stalls.
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		case (rx_tick[8:7])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= (rx_tick % 3 == 0);
			default: out_ready <= (rx_tick[4:0] < 5'd20);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(status), '0);
			end else begin
				oldest_expected = expected_results.pop_front();
				if (status !== oldest_expected.status)
					report_mismatch("status", 32'(status), 32'(oldest_expected.status));
				if (hit !== oldest_expected.hit)
					report_mismatch("hit", 32'(hit), 32'(oldest_expected.hit));
				if (buffer_slot !== oldest_expected.slot)
					report_mismatch("buffer_slot", 32'(buffer_slot), 32'(oldest_expected.slot));
				if (found_position !== oldest_expected.pos)
					report_mismatch("found_position", 32'(found_position),
						32'(oldest_expected.pos));
				if (prefetch_valid !== oldest_expected.pf_valid)
					report_mismatch("prefetch_valid", 32'(prefetch_valid),
						32'(oldest_expected.pf_valid));
				if (prefetch_page !== oldest_expected.pf_page)
					report_mismatch("prefetch_page", 32'(prefetch_page),
						32'(oldest_expected.pf_page));
				if (prefetch_busy !== oldest_expected.pf_busy)
					report_mismatch("prefetch_busy", 32'(prefetch_busy),
						32'(oldest_expected.pf_busy));
			end
		end
	end

	// Ends the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("lru_page_cache_with_readahead_unit verification failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_DEMAND;
		doc_id       = '0;
		page_number  = '0;
		angle_code   = '0;
		resolution   = '0;
		page_count   = '0;
		forward_only = 1'b0;
		cache_model_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_pause_until_drained();
		test_sequential_reading(700);
		test_random_noise(290);
		wait_for_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("lru_page_cache_with_readahead_unit verification clean");
		else
			$display("lru_page_cache_with_readahead_unit verification failed");
		$finish;
	end

endmodule
